[design/turtle_path_interpreter_assert.svh]
// Assertion macros for the checker file.
`ifndef TURTLE_PATH_INTERPRETER_ASSERT_SVH
`define TURTLE_PATH_INTERPRETER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TPI_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("tpi check failed");

// Next-cycle implication, off while reset is asserted.
`define TPI_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("tpi check failed");

// Next-cycle implication that also holds across reset.
`define TPI_ASSERT_NXT_ALL(name, ck, ante, cons) \
  name: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("tpi check failed");

`endif

[design/tpi_pkg.sv]
`timescale 1ns / 1ps
package tpi_pkg;

  localparam int STACK_DEPTH     = 64;
  localparam int SINE_TABLE_BITS = 10;

  localparam int SINE_N     = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W = SINE_TABLE_BITS + 1;
  localparam int STK_CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int STK_IDX_W  = $clog2(STACK_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_START_X       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = CFG_IDX_W'(4);

  localparam logic [23:0] RST_STEP_LENGTH   = 24'd65536;
  localparam logic [15:0] RST_TURN_ANGLE    = 16'd5461;
  localparam logic [15:0] RST_START_HEADING = 16'd16384;

  // ASCII codes
  localparam logic [7:0] SYM_PUSH        = 8'h5B;  // [
  localparam logic [7:0] SYM_POP         = 8'h5D;  // ]
  localparam logic [7:0] SYM_PLUS        = 8'h2B;  // +
  localparam logic [7:0] SYM_MINUS       = 8'h2D;  // -
  localparam logic [7:0] SYM_FWD_LOWER   = 8'h66;  // f
  localparam logic [7:0] SYM_UPPER_FIRST = 8'h41;  // A
  localparam logic [7:0] SYM_UPPER_LAST  = 8'h5A;  // Z

  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

  typedef struct packed {
    logic [7:0] symbol;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic signed [31:0] x_from;
    logic signed [31:0] y_from;
    logic signed [31:0] x_to;
    logic signed [31:0] y_to;
  } out_t;

  typedef struct packed {
    logic restart;
    logic push;
    logic pop;
    logic fwd;
  } op_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } pos_pair_t;

  typedef logic [14:0] sine_rom_t [0:SINE_N];

  // sin(x) for x in Q30, Taylor series through x^13, result Q15
  function automatic logic [14:0] taylor_q15(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    q = ($unsigned(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[14:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   tbl;
    logic [63:0] x;
    for (int k = 0; k <= SINE_N; k++) begin
      x      = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      tbl[k] = taylor_q15(x);
    end
    return tbl;
  endfunction

  // Quarter-wave address: mirror the index in odd quadrants
  function automatic logic [ROM_ADDR_W-1:0] rom_addr(input logic [15:0] phase);
    logic [SINE_TABLE_BITS-1:0] idx;
    idx = phase[13 -: SINE_TABLE_BITS];
    if (phase[14]) begin
      return ROM_ADDR_W'(SINE_N) - {1'b0, idx};
    end
    return {1'b0, idx};
  endfunction

endpackage

[design/turtle_path_interpreter.sv]
`timescale 1ns / 1ps
// Throughput: one symbol per cycle, sustained; the four stages stall independently,
// so a held output beat blocks the input only once every stage holds an item.
// Stages: input register, sine ROM read, step multiply, position update into the output reg.
// Reset (rst_n low, synchronous): pipeline empty, registers at defaults, position and
// heading zero, both stacks empty; stack memories are not cleared, so no init pass.
module turtle_path_interpreter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tpi_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tpi_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpi_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tpi_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------------
  logic [23:0]        step_length_r;
  logic [15:0]        turn_angle_r;
  logic [15:0]        start_heading_r;
  logic signed [15:0] start_x_r;
  logic signed [15:0] start_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r   <= RST_STEP_LENGTH;
      turn_angle_r    <= RST_TURN_ANGLE;
      start_heading_r <= RST_START_HEADING;
      start_x_r       <= '0;
      start_y_r       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP_LENGTH:   step_length_r   <= cfg_data[23:0];
        CFG_TURN_ANGLE:    turn_angle_r    <= cfg_data[15:0];
        CFG_START_HEADING: start_heading_r <= cfg_data[15:0];
        CFG_START_X:       start_x_r       <= cfg_data[15:0];
        CFG_START_Y:       start_y_r       <= cfg_data[15:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage advances when the next one is free or moving.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3;

  assign en3      = !out_valid_r || out_ready;
  assign en2      = !v3_r || en3;
  assign en1      = !v2_r || en2;
  assign in_ready = !v1_r || en1;

  // ---------------------------------------------------------------------------
  // Stage 1: input beat register, decode, heading and heading stack.
  // ---------------------------------------------------------------------------
  in_t in1_r;
  op_t op1;
  logic plus1, minus1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in1_r <= in_data;
    end
  end

  always_comb begin
    op1.restart = in1_r.restart;
    op1.push    = (in1_r.symbol == SYM_PUSH);
    op1.pop     = (in1_r.symbol == SYM_POP);
    op1.fwd     = ((in1_r.symbol >= SYM_UPPER_FIRST) && (in1_r.symbol <= SYM_UPPER_LAST)) ||
                  (in1_r.symbol == SYM_FWD_LOWER);
    plus1       = (in1_r.symbol == SYM_PLUS);
    minus1      = (in1_r.symbol == SYM_MINUS);
  end

  // The heading stack keeps its top entry in a register and prefetches the
  // entry below it, so a pop never waits on the memory read.
  logic [15:0]          heading_r, heading_nxt;
  logic [STK_CNT_W-1:0] hcnt_r, hcnt_nxt, hcnt_eff, hnos_cnt;
  logic [15:0]          htos_r, hnos_r;
  logic [15:0]          hstk_mem [STACK_DEPTH];
  logic [15:0]          h_eff;
  logic                 hpush_ok, hpop_ok, h_fire;

  assign h_fire = v1_r && en1;

  always_comb begin
    h_eff       = in1_r.restart ? start_heading_r : heading_r;
    hcnt_eff    = in1_r.restart ? '0 : hcnt_r;
    hpush_ok    = op1.push && (hcnt_eff < STK_CNT_W'(STACK_DEPTH));
    hpop_ok     = op1.pop && (hcnt_eff != '0);
    heading_nxt = heading_r;
    hcnt_nxt    = hcnt_r;
    if (h_fire) begin
      heading_nxt = h_eff;
      hcnt_nxt    = hcnt_eff;
      if (hpush_ok) begin
        hcnt_nxt = hcnt_eff + STK_CNT_W'(1);
      end else if (hpop_ok) begin
        heading_nxt = htos_r;
        hcnt_nxt    = hcnt_eff - STK_CNT_W'(1);
      end else if (plus1) begin
        heading_nxt = h_eff + turn_angle_r;
      end else if (minus1) begin
        heading_nxt = h_eff - turn_angle_r;
      end
    end
    hnos_cnt = hcnt_nxt - STK_CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
      hcnt_r    <= '0;
    end else begin
      heading_r <= heading_nxt;
      hcnt_r    <= hcnt_nxt;
    end
  end

  // Push writes slot count; the prefetch reads slot count-2 of the new count,
  // which is never the slot written at the same edge.
  always_ff @(posedge clk) begin
    if (h_fire && hpush_ok) begin
      hstk_mem[hcnt_eff[STK_IDX_W-1:0]] <= h_eff;
      htos_r                            <= h_eff;
    end else if (h_fire && hpop_ok) begin
      htos_r <= hnos_r;
    end
    hnos_r <= hstk_mem[hnos_cnt[STK_IDX_W-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: registered sine ROM read for cos and sin of the heading in use.
  // ---------------------------------------------------------------------------
  logic [ROM_ADDR_W-1:0] cos_addr, sin_addr;
  logic [15:0]           cos_phase;
  op_t                   op2_r;
  logic [14:0]           cos_mag_r, sin_mag_r;
  logic                  cos_neg_r, sin_neg_r;

  assign cos_phase = h_eff + QUARTER_TURN;
  assign cos_addr  = rom_addr(cos_phase);
  assign sin_addr  = rom_addr(h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en1) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op2_r     <= op1;
      cos_mag_r <= SINE_ROM[cos_addr];
      sin_mag_r <= SINE_ROM[sin_addr];
      cos_neg_r <= cos_phase[15];
      sin_neg_r <= h_eff[15];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 input: step length times signed cos and sin, registered.
  // ---------------------------------------------------------------------------
  logic signed [15:0] cos_val, sin_val;
  logic signed [24:0] step_s;
  logic signed [40:0] prod_x, prod_y;
  logic signed [40:0] prod_x_r, prod_y_r;
  op_t                op3_r;

  always_comb begin
    cos_val = cos_neg_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});
    sin_val = sin_neg_r ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
    step_s  = $signed({1'b0, step_length_r});
    prod_x  = step_s * cos_val;
    prod_y  = step_s * sin_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en2) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op3_r    <= op2_r;
      prod_x_r <= prod_x;
      prod_y_r <= prod_y;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: round the step, update position and position stack, load result.
  // The position stack repeats the heading stack's count so each side sees
  // the same push and pop decisions in item order.
  // ---------------------------------------------------------------------------
  logic [31:0]          pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic [31:0]          px_eff, py_eff, nx, ny, dx, dy;
  logic signed [40:0]   rnd_x, rnd_y;
  logic [STK_CNT_W-1:0] pcnt_r, pcnt_nxt, pcnt_eff, pnos_cnt;
  pos_pair_t            ptos_r, pnos_r;
  pos_pair_t            pstk_mem [STACK_DEPTH];
  logic                 ppush_ok, ppop_ok, p_fire;
  out_t                 out_data_r;

  assign p_fire = v3_r && en3;

  always_comb begin
    // round half up: add half an LSB, then floor
    rnd_x     = prod_x_r + 41'sd16384;
    rnd_y     = prod_y_r + 41'sd16384;
    dx        = {{6{rnd_x[40]}}, rnd_x[40:15]};
    dy        = {{6{rnd_y[40]}}, rnd_y[40:15]};
    px_eff    = op3_r.restart ? {start_x_r, 16'h0000} : pos_x_r;
    py_eff    = op3_r.restart ? {start_y_r, 16'h0000} : pos_y_r;
    nx        = px_eff + dx;
    ny        = py_eff + dy;
    pcnt_eff  = op3_r.restart ? '0 : pcnt_r;
    ppush_ok  = op3_r.push && (pcnt_eff < STK_CNT_W'(STACK_DEPTH));
    ppop_ok   = op3_r.pop && (pcnt_eff != '0);
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pcnt_nxt  = pcnt_r;
    if (p_fire) begin
      pos_x_nxt = px_eff;
      pos_y_nxt = py_eff;
      pcnt_nxt  = pcnt_eff;
      if (ppush_ok) begin
        pcnt_nxt = pcnt_eff + STK_CNT_W'(1);
      end else if (ppop_ok) begin
        pos_x_nxt = ptos_r.x;
        pos_y_nxt = ptos_r.y;
        pcnt_nxt  = pcnt_eff - STK_CNT_W'(1);
      end else if (op3_r.fwd) begin
        pos_x_nxt = nx;
        pos_y_nxt = ny;
      end
    end
    pnos_cnt = pcnt_nxt - STK_CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pcnt_r  <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p_fire && ppush_ok) begin
      pstk_mem[pcnt_eff[STK_IDX_W-1:0]] <= '{x: px_eff, y: py_eff};
      ptos_r                            <= '{x: px_eff, y: py_eff};
    end else if (p_fire && ppop_ok) begin
      ptos_r <= pnos_r;
    end
    pnos_r <= pstk_mem[pnos_cnt[STK_IDX_W-1:0]];
  end

  // Output register: one beat per forward symbol, held until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= v3_r && op3_r.fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (p_fire && op3_r.fwd) begin
      out_data_r.x_from <= px_eff;
      out_data_r.y_from <= py_eff;
      out_data_r.x_to   <= nx;
      out_data_r.y_to   <= ny;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/tpi_checker.sv]
`timescale 1ns / 1ps
`include "turtle_path_interpreter_assert.svh"
module tpi_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input tpi_pkg::out_t out_data
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // reset empties the result register
  `TPI_ASSERT_NXT_ALL(a_reset_clears_out, clk, !rst_n, !out_valid)
  // with the output side free, the pipeline always takes a new beat
  `TPI_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_valid || out_ready || in_beat, in_ready || !(!out_valid || out_ready))
  // a result beat stays up until taken
  `TPI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // and its payload does not move while it waits
  `TPI_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

endmodule

bind turtle_path_interpreter tpi_checker u_tpi_checker (.*);

[tb/sv/tb_turtle_path_interpreter.sv]
`timescale 1ns / 1ps
module tb_turtle_path_interpreter;
  import tpi_pkg::*;

  localparam int SINE_STEPS   = 1 << SINE_TABLE_BITS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT  = 8;     // pipeline is four stages deep
  localparam int HOLD_STRETCH = 300;
  localparam int REPORT_MAX   = 10;

  // pi/2 in Q30, the angle of the last quarter-wave entry
  localparam longint unsigned HALF_PI_Q30_TB = 64'd1686629713;

  // symbols that do nothing but sit next to meaningful ones
  localparam logic [7:0] SYM_IGNORED_LOWER = "g";
  localparam logic [7:0] SYM_BELOW_UPPER   = "@";
  localparam logic [7:0] SYM_NUL           = 8'h00;
  localparam logic [7:0] SYM_ALL_ONES      = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  turtle_path_interpreter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Turtle predictor: its own copy of registers, pen state and nesting stack
  // ---------------------------------------------------------------------------
  logic [23:0] reg_step;
  logic [15:0] reg_turn;
  logic [15:0] reg_start_heading;
  logic [15:0] reg_start_x;
  logic [15:0] reg_start_y;

  logic [31:0] pen_x;
  logic [31:0] pen_y;
  logic [15:0] pen_heading;
  logic [31:0] nest_x [STACK_DEPTH];
  logic [31:0] nest_y [STACK_DEPTH];
  logic [15:0] nest_heading [STACK_DEPTH];
  int          nest_depth;

  logic signed [15:0] quarter_sine [0:SINE_STEPS];

  // Segments predicted but not yet seen on the output channel, oldest first
  out_t pending_segments [$];

  // Bookkeeping for the summary and the verdict
  int symbols_sent;
  int restarts_sent;
  int segments_checked;
  int register_writes;
  int deepest_nesting;
  int full_pushes;
  int empty_pops;
  int fail_count;
  int cycle_count;

  // Idling knobs: upper bound of the per-beat gap on each side, and a one-off receiver hold
  int tx_gap_max;
  int rx_stall_max;
  int rx_hold_cycles;

  // Taylor series of sin through x^13, x in Q30, result rounded to Q15
  function automatic logic signed [15:0] series_sin_q15(input longint unsigned ang);
    longint unsigned sq;
    longint unsigned term;
    longint          sum;
    longint          q;
    sq   = (ang * ang) >> 30;
    term = ang;
    sum  = longint'(ang);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 16384) / 32768;
    if (q > 32767) begin
      q = 32767;
    end
    return 16'(q);
  endfunction

  // Fold a 16-bit phase onto the quarter-wave table
  function automatic logic signed [15:0] trig_of(input logic [15:0] phase);
    int                 idx;
    logic signed [15:0] mag;
    idx = int'(phase[13:0]) >> (14 - SINE_TABLE_BITS);
    mag = phase[14] ? quarter_sine[SINE_STEPS - idx] : quarter_sine[idx];
    return phase[15] ? -mag : mag;
  endfunction

  // step * trig / 2^15, rounded half toward +infinity, kept to 32 bits
  function automatic logic [31:0] step_delta(input logic signed [15:0] trig);
    longint prod;
    longint rounded;
    prod    = longint'(reg_step) * longint'(trig);
    rounded = (prod + 64'sd16384) >>> 15;
    return rounded[31:0];
  endfunction

  function automatic void reset_turtle();
    for (int k = 0; k <= SINE_STEPS; k++) begin
      quarter_sine[k] = series_sin_q15((HALF_PI_Q30_TB * 64'(k)) >> SINE_TABLE_BITS);
    end
    reg_step          = RST_STEP_LENGTH;
    reg_turn          = RST_TURN_ANGLE;
    reg_start_heading = RST_START_HEADING;
    reg_start_x       = '0;
    reg_start_y       = '0;
    pen_x             = '0;
    pen_y             = '0;
    pen_heading       = '0;
    nest_depth        = 0;
  endfunction

  function automatic void latch_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_STEP_LENGTH:   reg_step          = value[23:0];
      CFG_TURN_ANGLE:    reg_turn          = value[15:0];
      CFG_START_HEADING: reg_start_heading = value[15:0];
      CFG_START_X:       reg_start_x       = value[15:0];
      CFG_START_Y:       reg_start_y       = value[15:0];
      default: ;  // unused index: drop the write
    endcase
  endfunction

  // Apply one accepted symbol; queue the segment a forward move draws
  function automatic void advance_turtle(input in_t beat);
    out_t        seg;
    logic [31:0] nx;
    logic [31:0] ny;
    symbols_sent++;
    if (beat.restart) begin
      restarts_sent++;
      pen_x       = {reg_start_x, 16'h0000};
      pen_y       = {reg_start_y, 16'h0000};
      pen_heading = reg_start_heading;
      nest_depth  = 0;
    end
    if (beat.symbol == SYM_PUSH) begin
      if (nest_depth < STACK_DEPTH) begin
        nest_x[nest_depth]       = pen_x;
        nest_y[nest_depth]       = pen_y;
        nest_heading[nest_depth] = pen_heading;
        nest_depth++;
        if (nest_depth > deepest_nesting) begin
          deepest_nesting = nest_depth;
        end
      end else begin
        full_pushes++;
      end
    end else if (beat.symbol == SYM_POP) begin
      if (nest_depth > 0) begin
        nest_depth--;
        pen_x       = nest_x[nest_depth];
        pen_y       = nest_y[nest_depth];
        pen_heading = nest_heading[nest_depth];
      end else begin
        empty_pops++;
      end
    end else if (beat.symbol == SYM_PLUS) begin
      pen_heading = pen_heading + reg_turn;
    end else if (beat.symbol == SYM_MINUS) begin
      pen_heading = pen_heading - reg_turn;
    end else if ((beat.symbol >= SYM_UPPER_FIRST && beat.symbol <= SYM_UPPER_LAST) ||
                 beat.symbol == SYM_FWD_LOWER) begin
      // cos is sin a quarter turn ahead
      nx = pen_x + step_delta(trig_of(16'(pen_heading + QUARTER_TURN)));
      ny = pen_y + step_delta(trig_of(pen_heading));
      seg.x_from = pen_x;
      seg.y_from = pen_y;
      seg.x_to   = nx;
      seg.y_to   = ny;
      pending_segments.push_back(seg);
      pen_x = nx;
      pen_y = ny;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one symbol; valid stays high on return so a back-to-back beat
  // needs no second assignment in the same step.
  task automatic send_symbol(input logic [7:0] sym, input logic restart);
    in_t beat;
    int  gap;
    beat.symbol  = sym;
    beat.restart = restart;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    advance_turtle(beat);
  endtask

  // Drop valid, let every predicted segment arrive, then let the pipe settle
  // (pushes, pops and turns leave no trace on the output).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_segments.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    latch_register(idx, value);
    register_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write a 16-bit register with junk in the unused upper bits
  task automatic write_half(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    write_register(idx, {8'($urandom), value});
  endtask

  function automatic logic [15:0] pick_phase16();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'(16'h1000 * $urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_start16();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed turtle programs: moves, turns and brackets, some noise
  function automatic logic [7:0] pick_symbol();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      return 8'(SYM_UPPER_FIRST + $urandom_range(0, 25));
    end else if (roll < 40) begin
      return SYM_FWD_LOWER;
    end else if (roll < 50) begin
      return SYM_PLUS;
    end else if (roll < 60) begin
      return SYM_MINUS;
    end else if (roll < 73) begin
      return SYM_PUSH;
    end else if (roll < 85) begin
      return SYM_POP;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall per beat, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid && rx_hold_cycles == 0) begin
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Segment checker: compare each accepted beat with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected segment from (%h,%h) to (%h,%h)",
                   out_data.x_from, out_data.y_from, out_data.x_to, out_data.y_to);
        end
      end else begin
        want = pending_segments.pop_front();
        segments_checked++;
        if (out_data.x_from !== want.x_from || out_data.y_from !== want.y_from ||
            out_data.x_to !== want.x_to || out_data.y_to !== want.y_to) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("segment %0d: expected (%h,%h)->(%h,%h), got (%h,%h)->(%h,%h)",
                     segments_checked, want.x_from, want.y_from, want.x_to, want.y_to,
                     out_data.x_from, out_data.y_from, out_data.x_to, out_data.y_to);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding",
               cycle_count, pending_segments.size());
      $display("tb_turtle_path_interpreter: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: every kind of symbol, ignored bytes, restart over a stack
  task automatic test_reset_defaults();
    send_symbol(SYM_UPPER_FIRST + 8'd5, 1'b0);  // F from the origin, heading zero
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_FWD_LOWER, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_UPPER_LAST, 1'b0);
    send_symbol(SYM_PUSH, 1'b0);
    send_symbol(SYM_UPPER_FIRST, 1'b0);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_UPPER_FIRST + 8'd1, 1'b0);
    send_symbol(SYM_POP, 1'b0);
    send_symbol(SYM_UPPER_FIRST + 8'd5, 1'b0);
    send_symbol(SYM_IGNORED_LOWER, 1'b0);
    send_symbol(SYM_BELOW_UPPER, 1'b0);
    send_symbol(SYM_NUL, 1'b0);
    send_symbol(SYM_ALL_ONES, 1'b0);
    send_symbol(SYM_PUSH, 1'b0);
    send_symbol(SYM_PUSH, 1'b0);
    // restart empties the stack first, so this pop finds nothing
    send_symbol(SYM_POP, 1'b1);
    send_symbol(SYM_UPPER_FIRST + 8'd5, 1'b0);
    send_symbol(SYM_POP, 1'b0);
    send_symbol(SYM_FWD_LOWER, 1'b1);
    send_symbol(SYM_UPPER_LAST + 8'd1, 1'b0);  // '[' sits right after Z
    send_symbol(SYM_POP, 1'b0);
    send_symbol(SYM_UPPER_LAST, 1'b0);
    wait_idle();
  endtask

  // Both extremes of every register, and writes to the unused indexes
  task automatic test_register_extremes();
    write_register(CFG_STEP_LENGTH, 24'h000000);
    write_half(CFG_TURN_ANGLE, 16'h0000);
    write_half(CFG_START_HEADING, 16'h0000);
    write_half(CFG_START_X, 16'h8000);
    write_half(CFG_START_Y, 16'h7FFF);
    for (int i = int'(CFG_START_Y) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_register(CFG_IDX_W'(i), 24'($urandom));
    end
    send_symbol(SYM_UPPER_FIRST, 1'b1);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_FWD_LOWER, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_UPPER_LAST, 1'b0);
    wait_idle();

    // largest step from the far corner: positions wrap past 2^31
    write_register(CFG_STEP_LENGTH, 24'hFFFFFF);
    write_half(CFG_TURN_ANGLE, 16'hFFFF);
    write_half(CFG_START_HEADING, 16'hFFFF);
    write_half(CFG_START_X, 16'h7FFF);
    write_half(CFG_START_Y, 16'h8000);
    send_symbol(SYM_UPPER_FIRST, 1'b1);
    repeat (4) send_symbol(SYM_UPPER_LAST, 1'b0);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_PLUS, 1'b0);
    repeat (4) send_symbol(SYM_FWD_LOWER, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    repeat (4) send_symbol(SYM_UPPER_FIRST + 8'd6, 1'b0);
    wait_idle();
  endtask

  // Fill the stack past its depth, then pop past empty
  task automatic test_stack_limits();
    write_register(CFG_STEP_LENGTH, 24'h030000);
    write_half(CFG_TURN_ANGLE, 16'h0A3D);
    write_half(CFG_START_HEADING, 16'h2000);
    write_half(CFG_START_X, 16'hFFF0);
    write_half(CFG_START_Y, 16'h0010);
    send_symbol(SYM_FWD_LOWER, 1'b1);
    repeat (STACK_DEPTH + 2) begin
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_UPPER_FIRST + 8'd5, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
    end
    repeat (STACK_DEPTH + 3) begin
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_UPPER_FIRST + 8'd5, 1'b0);
    end
    wait_idle();
  endtask

  // Hold the output off while the sender keeps offering, so the pipe backs up
  task automatic test_output_backpressure();
    tx_gap_max     = 0;
    rx_hold_cycles = HOLD_STRETCH;
    repeat (120) send_symbol(pick_symbol(), 1'b0);
    wait_idle();
    tx_gap_max = 3;
  endtask

  // Random register settings, each followed by a random turtle program
  task automatic test_random_programs();
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0:       write_register(CFG_STEP_LENGTH, 24'h000000);
        1:       write_register(CFG_STEP_LENGTH, 24'hFFFFFF);
        2:       write_register(CFG_STEP_LENGTH, 24'($urandom_range(0, 24'h0FFFFF)));
        default: write_register(CFG_STEP_LENGTH, 24'($urandom));
      endcase
      write_half(CFG_TURN_ANGLE, pick_phase16());
      write_half(CFG_START_HEADING, pick_phase16());
      write_half(CFG_START_X, pick_start16());
      write_half(CFG_START_Y, pick_start16());
      if ($urandom_range(0, 3) == 0) begin
        write_register(CFG_IDX_W'($urandom_range(int'(CFG_START_Y) + 1,
                                                 (1 << CFG_IDX_W) - 1)), 24'($urandom));
      end
      // first phase runs flat out on both sides
      tx_gap_max   = (phase == 0) ? 0 : 3;
      rx_stall_max = (phase == 0) ? 0 : 3;
      repeat (190) send_symbol(pick_symbol(), $urandom_range(0, 49) == 0);
      wait_idle();
    end
    tx_gap_max   = 3;
    rx_stall_max = 3;
  endtask

  initial begin
    reset_turtle();
    tx_gap_max     = 3;
    rx_stall_max   = 3;
    rx_hold_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_stack_limits();
    test_output_backpressure();
    test_random_programs();
    wait_idle();

    $display("covered %0d symbols (%0d with restart) and %0d register writes;",
             symbols_sent, restarts_sent, register_writes);
    $display("checked %0d segments, nesting reached %0d, %0d pushes on full, %0d pops on empty",
             segments_checked, deepest_nesting, full_pushes, empty_pops);
    if (fail_count == 0) begin
      $display("tb_turtle_path_interpreter: PASS");
    end else begin
      $display("%0d segment failures", fail_count);
      $display("tb_turtle_path_interpreter: FAIL");
    end
    $finish;
  end

endmodule
